### design/bda_pkg.sv
// Shared types and constants for the button debounce and auto-repeat unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package bda_pkg;

  localparam int CMD_W = 3;
  localparam int BTN_W = 2;
  localparam int CNT_W = 8;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 3'd0,
    CMD_LEVEL = 3'd1,
    CMD_PRESS = 3'd2,
    CMD_PULSE = 3'd3,
    CMD_LOCK  = 3'd4
  } cmd_e;

  // Button code that addresses every button at once
  localparam logic [BTN_W-1:0] BTN_ANY = 2'd3;

  // Register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_FIRST    = 2'd1;
  localparam logic [1:0] REG_INTERVAL = 2'd2;

  localparam logic [CNT_W-1:0] RST_DEBOUNCE = 8'd5;
  localparam logic [CNT_W-1:0] RST_FIRST    = 8'd50;
  localparam logic [CNT_W-1:0] RST_INTERVAL = 8'd10;

  typedef struct packed {
    logic [CNT_W-1:0] debounce_ticks;
    logic [CNT_W-1:0] first_repeat_delay;
    logic [CNT_W-1:0] repeat_interval;
  } cfg_t;

  // Per-button request for the item being processed
  typedef struct packed {
    logic fire;
    cmd_e cmd;
    logic sel;
    logic any;
  } cell_req_t;

endpackage

`default_nettype wire

### design/bda_cfg_regs.sv
// APB-style configuration registers for the debounce and repeat timing.
// Depends on bda_pkg.
`default_nettype none

module bda_cfg_regs
  import bda_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready,
  output cfg_t                       cfg
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_idx    = cfg_paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_DEBOUNCE: cfg_nxt.debounce_ticks     = cfg_pwdata[CNT_W-1:0];
        REG_FIRST:    cfg_nxt.first_repeat_delay = cfg_pwdata[CNT_W-1:0];
        REG_INTERVAL: cfg_nxt.repeat_interval    = cfg_pwdata[CNT_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEBOUNCE: cfg_prdata = {{(CFG_DATA_W-CNT_W){1'b0}}, cfg_r.debounce_ticks};
      REG_FIRST:    cfg_prdata = {{(CFG_DATA_W-CNT_W){1'b0}}, cfg_r.first_repeat_delay};
      REG_INTERVAL: cfg_prdata = {{(CFG_DATA_W-CNT_W){1'b0}}, cfg_r.repeat_interval};
      default:      cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks     <= RST_DEBOUNCE;
      cfg_r.first_repeat_delay <= RST_FIRST;
      cfg_r.repeat_interval    <= RST_INTERVAL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

### design/bda_btn_cell.sv
// State and update logic of one button: pulse count, press flag, debounce
// and repeat countdowns, lock. Depends on bda_pkg.
`default_nettype none

module bda_btn_cell
  import bda_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cell_req_t req,
  input  wire logic      level,
  input  wire cfg_t      cfg,
  output logic           hit
);

  logic [CNT_W-1:0] count_r,  count_nxt;
  logic             press_r,  press_nxt;
  logic [CNT_W-1:0] deb_r,    deb_nxt;
  logic [CNT_W-1:0] rep_r,    rep_nxt;
  logic             lock_r,   lock_nxt;
  logic [CNT_W-1:0] rep_dec;
  logic [CNT_W-1:0] deb_dec;
  logic             cond;
  logic             asked;

  assign asked   = req.any | (req.sel & ~lock_r);
  assign rep_dec = rep_r - 1'b1;
  assign deb_dec = (deb_r != '0) ? deb_r - 1'b1 : deb_r;

  always_comb begin
    case (req.cmd)
      CMD_LEVEL: cond = level;
      CMD_PRESS: cond = press_r;
      CMD_PULSE: cond = (count_r != '0);
      default:   cond = 1'b0;
    endcase
  end

  assign hit = asked & cond;

  always_comb begin
    count_nxt = count_r;
    press_nxt = press_r;
    deb_nxt   = deb_r;
    rep_nxt   = rep_r;
    lock_nxt  = lock_r;
    if (req.fire) begin
      case (req.cmd)
        CMD_TICK: begin
          if (level) begin
            if (!lock_r) begin
              if (deb_r == '0) begin
                count_nxt = count_r + 1'b1;
                press_nxt = 1'b1;
                deb_nxt   = cfg.debounce_ticks;
                rep_nxt   = cfg.first_repeat_delay;
              end else if (rep_dec == '0) begin
                count_nxt = count_r + 1'b1;
                rep_nxt   = cfg.repeat_interval;
              end else begin
                rep_nxt = rep_dec;
              end
            end
          end else begin
            // first release after a press, debounce count still full: drop and lock
            if (deb_r == cfg.debounce_ticks) begin
              count_nxt = '0;
              press_nxt = 1'b0;
              lock_nxt  = 1'b1;
            end
            deb_nxt = deb_dec;
            if (deb_dec == '0) begin
              lock_nxt = 1'b0;
            end
          end
        end
        CMD_PRESS: begin
          if (hit) begin
            press_nxt = 1'b0;
          end
        end
        CMD_PULSE: begin
          if (hit) begin
            count_nxt = count_r - 1'b1;
          end
        end
        CMD_LOCK: lock_nxt = 1'b1;
        default: lock_nxt = lock_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      press_r <= 1'b0;
      deb_r   <= '0;
      rep_r   <= '0;
      lock_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      press_r <= press_nxt;
      deb_r   <= deb_nxt;
      rep_r   <= rep_nxt;
      lock_r  <= lock_nxt;
    end
  end

endmodule

`default_nettype wire

### design/button_debounce_autorepeat_unit.sv
// Top level of the button debounce and auto-repeat unit: input register,
// button cells, result register and configuration registers. Depends on bda_pkg.
`default_nettype none

// The unit accepts one command item per clock cycle while its output is not
// stalled and returns exactly one result item for each, in order. An item is
// captured in the input register; when it advances it updates every button
// cell and forms its answer, which is registered in the result register and
// shown from there. The rate is set by the read-modify-write of the
// per-button state; the input side keeps accepting while a result waits,
// until both registers are full. The user must write the timing registers
// over the configuration port only while the unit is idle; the block itself
// does not enforce this. A release is judged against debounce_ticks, repeat
// pulses against first_repeat_delay and repeat_interval.
module button_debounce_autorepeat_unit
  import bda_pkg::*;
#(
  parameter int BUTTONS = 3,
  localparam int IN_DATA_W = ((CMD_W + BTN_W + BUTTONS + 7) / 8) * 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // {pins, button, cmd} from bit 0 up: cmd[2:0], button[4:3], pins above
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // answer in bit 0, rest zero
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  logic               in_valid_r;
  logic [CMD_W-1:0]   cmd_r;
  logic [BTN_W-1:0]   button_r;
  logic [BUTTONS-1:0] pins_r;
  logic               out_valid_r;
  logic               answer_r;
  logic               advance;
  logic               in_fire;
  logic [BUTTONS-1:0] hits;
  cfg_t               cfg;

  assign advance   = in_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~in_valid_r | advance;
  assign in_fire   = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r    <= in_tdata[CMD_W-1:0];
      button_r <= in_tdata[CMD_W +: BTN_W];
      pins_r   <= in_tdata[CMD_W+BTN_W +: BUTTONS];
    end
  end

  bda_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  for (genvar i = 0; i < BUTTONS; i++) begin : g_btn
    localparam logic [3:0] IDX = 4'(i);
    cell_req_t req;

    always_comb begin
      req.fire = advance;
      req.cmd  = cmd_e'(cmd_r);
      req.any  = (button_r == BTN_ANY);
      req.sel  = ({2'b00, button_r} == IDX) & (button_r != BTN_ANY);
    end

    bda_btn_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .req   (req),
      .level (pins_r[i]),
      .cfg   (cfg),
      .hit   (hits[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      answer_r <= |hits;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-1){1'b0}}, answer_r};

endmodule

`default_nettype wire

### dv/debounce_answer_checker.sv
// Checker for the button debounce and auto-repeat unit: watches the command, answer
// and register ports, predicts each answer and compares. Depends on bda_pkg.
module debounce_answer_checker
  import bda_pkg::*;
#(
  parameter int BUTTONS = 3,
  parameter int IN_W = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_W-1:0]       in_tdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic                  cfg_pready,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output int                    fail_count,
  output int                    answers_due
);

  logic [CNT_W-1:0] debounce_ticks;
  logic [CNT_W-1:0] first_delay;
  logic [CNT_W-1:0] interval;

  logic [CNT_W-1:0] pulses [BUTTONS];
  logic [CNT_W-1:0] deb_left [BUTTONS];
  logic [CNT_W-1:0] rep_left [BUTTONS];
  logic             pressed [BUTTONS];
  logic             locked [BUTTONS];

  logic [OUT_DATA_W-1:0] due_answers [$];

  initial begin
    fail_count = 0;
    answers_due = 0;
  end

  task automatic tick_button(input int b, input logic level);
    if (level) begin
      if (!locked[b]) begin
        if (deb_left[b] == '0) begin
          pulses[b] = pulses[b] + 8'd1;
          pressed[b] = 1'b1;
          deb_left[b] = debounce_ticks;
          rep_left[b] = first_delay;
        end else begin
          rep_left[b] = rep_left[b] - 8'd1;
          if (rep_left[b] == '0) begin
            pulses[b] = pulses[b] + 8'd1;
            rep_left[b] = interval;
          end
        end
      end
    end else begin
      // the first release after a press, debounce count still full, clears the button and locks it
      if (deb_left[b] == debounce_ticks) begin
        pulses[b] = '0;
        pressed[b] = 1'b0;
        locked[b] = 1'b1;
      end
      if (deb_left[b] != '0) deb_left[b] = deb_left[b] - 8'd1;
      if (deb_left[b] == '0) locked[b] = 1'b0;
    end
  endtask

  task automatic predict_answer(input logic [CMD_W-1:0] cmd, input logic [BTN_W-1:0] btn,
                                input logic [BUTTONS-1:0] pins, output logic ans);
    ans = 1'b0;
    case (cmd)
      CMD_TICK: begin
        for (int i = 0; i < BUTTONS; i++) tick_button(i, pins[i]);
      end
      CMD_LOCK: begin
        for (int i = 0; i < BUTTONS; i++) locked[i] = 1'b1;
      end
      CMD_LEVEL, CMD_PRESS, CMD_PULSE: begin
        // the any-button form ignores locks, a single-button one honors it
        for (int i = 0; i < BUTTONS; i++) begin
          if (btn == BTN_ANY || (int'(btn) == i && !locked[i])) begin
            if (cmd == CMD_LEVEL) begin
              if (pins[i]) ans = 1'b1;
            end else if (cmd == CMD_PRESS) begin
              if (pressed[i]) begin
                pressed[i] = 1'b0;
                ans = 1'b1;
              end
            end else if (pulses[i] != '0) begin
              pulses[i] = pulses[i] - 8'd1;
              ans = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    logic ans;
    logic [OUT_DATA_W-1:0] want;
    if (!rst_n) begin
      debounce_ticks = RST_DEBOUNCE;
      first_delay = RST_FIRST;
      interval = RST_INTERVAL;
      for (int i = 0; i < BUTTONS; i++) begin
        pulses[i] = '0;
        deb_left[i] = '0;
        rep_left[i] = '0;
        pressed[i] = 1'b0;
        locked[i] = 1'b0;
      end
      due_answers.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_DEBOUNCE: debounce_ticks = cfg_pwdata[CNT_W-1:0];
          REG_FIRST:    first_delay = cfg_pwdata[CNT_W-1:0];
          REG_INTERVAL: interval = cfg_pwdata[CNT_W-1:0];
          default: ;
        endcase
      end
      // retire the oldest answer before queuing a new one
      if (out_tvalid && out_tready) begin
        if (due_answers.size() == 0) begin
          $display("%0t: answer with none expected, expected none, got %0h", $time, out_tdata);
          fail_count++;
        end else begin
          want = due_answers.pop_front();
          if (out_tdata !== want) begin
            $display("%0t: answer mismatch, expected %0h, got %0h", $time, want, out_tdata);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predict_answer(in_tdata[CMD_W-1:0], in_tdata[CMD_W+BTN_W-1:CMD_W],
                       in_tdata[CMD_W+BTN_W+BUTTONS-1:CMD_W+BTN_W], ans);
        want = '0;
        want[0] = ans;
        due_answers.push_back(want);
      end
    end
    answers_due <= due_answers.size();
  end

endmodule

### dv/button_debounce_autorepeat_unit_test.sv
// Testbench top for the button debounce and auto-repeat unit: clock, reset, command
// stimulus, register writes and verdict. Depends on bda_pkg and debounce_answer_checker.
module button_debounce_autorepeat_unit_test
  import bda_pkg::*;
;

  localparam int BUTTONS = 3;
  localparam int IN_W = ((CMD_W + BTN_W + BUTTONS + 7) / 8) * 8;
  localparam int LONG_HOLD = 80;

  localparam logic [BTN_W-1:0] BTN_UP     = 2'd0;
  localparam logic [BTN_W-1:0] BTN_SELECT = 2'd1;
  localparam logic [BTN_W-1:0] BTN_DOWN   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [IN_W-1:0] in_tdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  int fail_count;
  int answers_due;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int holds_asked = 0;
  int holds_served = 0;
  int hold_left = 0;
  logic [BUTTONS-1:0] held_pins = '0;

  always #5 clk = ~clk;

  button_debounce_autorepeat_unit #(.BUTTONS(BUTTONS)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  debounce_answer_checker #(.BUTTONS(BUTTONS), .IN_W(IN_W)) answer_check (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_pready(cfg_pready), .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .fail_count(fail_count), .answers_due(answers_due)
  );

  // Receiver: random stalls, or a long hold-off when one is asked for
  always @(negedge clk) begin
    if (holds_served != holds_asked) begin
      holds_served = holds_asked;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [BTN_W-1:0] btn,
                           input logic [BUTTONS-1:0] pins);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {pins, btn, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CNT_W-1:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {{(CFG_DATA_W-CNT_W){1'b0}}, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic set_timing(input logic [CNT_W-1:0] deb, input logic [CNT_W-1:0] first,
                            input logic [CNT_W-1:0] gap);
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_FIRST, first);
    write_reg(REG_INTERVAL, gap);
  endtask

  // Drop valid and hold until every answer is back
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (answers_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      1: begin tx_idle_pct = 48; rx_stall_pct = 0;  end
      2: begin tx_idle_pct = 0;  rx_stall_pct = 48; end
      default: begin tx_idle_pct = 30; rx_stall_pct = 30; end
    endcase
  endtask

  // Mostly ticks with slowly changing pins so presses are held long enough
  // to reach the repeat logic; queries, locks and spare codes mixed in.
  task automatic run_phase(input int count, input int flip_pm);
    int pick;
    logic [CMD_W-1:0] cmd;
    logic [BUTTONS-1:0] pins;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
        for (int i = 0; i < BUTTONS; i++)
          if ($urandom_range(0, 999) < flip_pm) held_pins[i] = ~held_pins[i];
        send_item(CMD_TICK, BTN_W'($urandom_range(0, 3)), held_pins);
      end else if (pick < 93) begin
        cmd = CMD_LEVEL + CMD_W'($urandom_range(0, 2));
        pins = ($urandom_range(0, 3) == 0) ? BUTTONS'($urandom_range(0, 7)) : held_pins;
        send_item(cmd, BTN_W'($urandom_range(0, 3)), pins);
      end else if (pick < 96) begin
        send_item(CMD_LOCK, BTN_W'($urandom_range(0, 3)), BUTTONS'($urandom_range(0, 7)));
      end else if (pick < 98) begin
        send_item(CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)),
                  BTN_W'($urandom_range(0, 3)), BUTTONS'($urandom_range(0, 7)));
      end else begin
        // bounce: one tick at a random level
        send_item(CMD_TICK, BTN_W'($urandom_range(0, 3)), BUTTONS'($urandom_range(0, 7)));
      end
    end
  endtask

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    set_idling(0);
    set_timing(8'd2, 8'd3, 8'd2);
    send_item(CMD_LEVEL, BTN_ANY, 3'b000);
    send_item(CMD_LEVEL, BTN_UP, 3'b001);
    send_item(CMD_PRESS, BTN_DOWN, 3'b000);
    send_item(CMD_PULSE, BTN_ANY, 3'b000);
    repeat (4) send_item(CMD_TICK, BTN_UP, 3'b111);
    send_item(CMD_PRESS, BTN_UP, 3'b111);
    send_item(CMD_PRESS, BTN_ANY, 3'b111);
    send_item(CMD_PRESS, BTN_ANY, 3'b111);
    send_item(CMD_PULSE, BTN_SELECT, 3'b111);
    send_item(CMD_PULSE, BTN_ANY, 3'b111);
    send_item(CMD_TICK, BTN_UP, 3'b010);
    send_item(CMD_PULSE, BTN_UP, 3'b010);
    send_item(CMD_LEVEL, BTN_DOWN, 3'b100);
    send_item(CMD_TICK, BTN_SELECT, 3'b000);
    send_item(CMD_LOCK, BTN_UP, 3'b000);
    send_item(CMD_LEVEL, BTN_UP, 3'b001);
    send_item(CMD_LEVEL, BTN_ANY, 3'b100);
    send_item(CMD_TICK, BTN_ANY, 3'b111);
    send_item(CMD_TICK, BTN_ANY, 3'b000);
    send_item(CMD_SPARE_LO, BTN_ANY, 3'b111);
    send_item(CMD_SPARE_HI, BTN_DOWN, 3'b111);
    send_item(CMD_PULSE, BTN_ANY, 3'b111);
    wait_idle();

    // Hold the up button with a pulse every tick until its count wraps
    set_timing(8'd1, 8'd1, 8'd1);
    repeat (262) send_item(CMD_TICK, BTN_UP, 3'b001);
    repeat (3) send_item(CMD_PULSE, BTN_UP, 3'b001);
    send_item(CMD_PRESS, BTN_ANY, 3'b001);
    send_item(CMD_TICK, BTN_UP, 3'b000);
    send_item(CMD_PULSE, BTN_ANY, 3'b000);
    wait_idle();

    for (int k = 0; k < 8; k++) begin
      set_idling(k % 4);
      case (k)
        0: begin set_timing(8'd255, 8'd255, 8'd255); run_phase(200, 3); end
        1: begin set_timing(8'd1, 8'd1, 8'd1); run_phase(200, 100); end
        2: begin set_timing(RST_DEBOUNCE, RST_FIRST, RST_INTERVAL); run_phase(200, 20); end
        default: begin
          set_timing(CNT_W'($urandom_range(1, 6)), CNT_W'($urandom_range(1, 10)),
                     CNT_W'($urandom_range(1, 5)));
          if (k == 4) holds_asked++;
          run_phase(200, int'($urandom_range(30, 200)));
        end
      endcase
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0 && answers_due == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
